// ----- design/dpb_pkg.sv -----
package dpb_pkg;

    localparam int REG_IDX_W = 3;
    localparam int REG_DATA_W = 63;

    localparam logic [REG_IDX_W-1:0] REG_FOCAL_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROT_A       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROT_B       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROT_C       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TRANSLATION = 3'd7;

    localparam logic [19:0] FOCAL_RESET    = 20'd8000;
    localparam logic [15:0] CENTER_X_RESET = 16'd5120;
    localparam logic [15:0] CENTER_Y_RESET = 16'd3840;
    localparam logic [47:0] ROT_A_RESET    = 48'h4000_0000_0000;
    localparam logic [47:0] ROT_B_RESET    = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_C_RESET    = 48'h0000_0000_4000;

    localparam logic [23:0] DEPTH_MIN  = 24'd656;
    localparam logic [23:0] DEPTH_MAX  = 24'd6553600;
    localparam logic [7:0]  MASK_LIMIT = 8'd128;
    localparam logic [7:0]  RED_FULL   = 8'd255;

    // (2*|num|*z + f) and the 2*f divisor of the rounded projection
    localparam int NUM_W = 42;
    localparam int DEN_W = 21;
    localparam int CAM_W = 42;
    localparam int COLOR_W = 24;

    typedef struct packed {
        logic [19:0] focal_x;   // zero already mapped to one
        logic [19:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [47:0] rot_a;
        logic [47:0] rot_b;
        logic [47:0] rot_c;
        logic [62:0] translation;
    } cfg_t;

endpackage

// ----- design/dpb_cfg_regs.sv -----
module dpb_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dpb_pkg::REG_IDX_W-1:0]       cfg_addr,
    input  logic [dpb_pkg::REG_DATA_W-1:0]      cfg_wdata,
    output dpb_pkg::cfg_t                       cfg
);
    import dpb_pkg::*;

    logic [19:0] focal_x_reg;
    logic [19:0] focal_y_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [47:0] rot_a_reg;
    logic [47:0] rot_b_reg;
    logic [47:0] rot_c_reg;
    logic [62:0] translation_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= FOCAL_RESET;
            focal_y_reg     <= FOCAL_RESET;
            center_x_reg    <= CENTER_X_RESET;
            center_y_reg    <= CENTER_Y_RESET;
            rot_a_reg       <= ROT_A_RESET;
            rot_b_reg       <= ROT_B_RESET;
            rot_c_reg       <= ROT_C_RESET;
            translation_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FOCAL_X:     focal_x_reg     <= cfg_wdata[19:0];
                REG_FOCAL_Y:     focal_y_reg     <= cfg_wdata[19:0];
                REG_CENTER_X:    center_x_reg    <= cfg_wdata[15:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_wdata[15:0];
                REG_ROT_A:       rot_a_reg       <= cfg_wdata[47:0];
                REG_ROT_B:       rot_b_reg       <= cfg_wdata[47:0];
                REG_ROT_C:       rot_c_reg       <= cfg_wdata[47:0];
                REG_TRANSLATION: translation_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a zero focal length behaves as one
    always_comb begin
        cfg.focal_x     = (focal_x_reg == '0) ? 20'd1 : focal_x_reg;
        cfg.focal_y     = (focal_y_reg == '0) ? 20'd1 : focal_y_reg;
        cfg.center_x    = center_x_reg;
        cfg.center_y    = center_y_reg;
        cfg.rot_a       = rot_a_reg;
        cfg.rot_b       = rot_b_reg;
        cfg.rot_c       = rot_c_reg;
        cfg.translation = translation_reg;
    end

endmodule

// ----- design/dpb_div_pipe.sv -----
module dpb_div_pipe #(
    parameter int N_W    = 42,
    parameter int D_W    = 21,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [N_W-1:0]    in_num,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [D_W-1:0]    den,
    output logic              out_valid,
    output logic [N_W-1:0]    out_quo,
    output logic [SIDE_W-1:0] out_side
);
    // one quotient bit per stage; the dividend register fills with quotient bits
    logic              vld_reg  [N_W];
    logic [D_W-1:0]    rem_reg  [N_W];
    logic [N_W-1:0]    nq_reg   [N_W];
    logic [SIDE_W-1:0] side_reg [N_W];

    for (genvar k = 0; k < N_W; k++) begin : g_stage
        logic              prev_vld;
        logic [D_W-1:0]    prev_rem;
        logic [N_W-1:0]    prev_nq;
        logic [SIDE_W-1:0] prev_side;
        logic [D_W:0]      trial;
        logic              ge;
        logic [D_W:0]      diff;

        if (k == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_rem  = '0;
            assign prev_nq   = in_num;
            assign prev_side = in_side;
        end else begin : g_next
            assign prev_vld  = vld_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_nq   = nq_reg[k-1];
            assign prev_side = side_reg[k-1];
        end

        assign trial = {prev_rem, prev_nq[N_W-1]};
        assign ge    = trial >= {1'b0, den};
        assign diff  = trial - {1'b0, den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
                nq_reg[k]   <= {prev_nq[N_W-2:0], ge};
                side_reg[k] <= prev_side;
            end
        end
    end

    assign out_valid = vld_reg[N_W-1];
    assign out_quo   = nq_reg[N_W-1];
    assign out_side  = side_reg[N_W-1];

endmodule

// ----- design/dpb_axis.sv -----
module dpb_axis (
    input  logic                               aclk,
    input  logic                               adv,
    input  logic [47:0]                        rot_row,
    input  logic [20:0]                        trans,
    input  logic signed [dpb_pkg::CAM_W-1:0]   cam_x,
    input  logic signed [dpb_pkg::CAM_W-1:0]   cam_y,
    input  logic [23:0]                        cam_z,
    output logic [31:0]                        world
);
    import dpb_pkg::*;

    localparam int PROD_W = CAM_W + 16;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [31:0]              world_reg;

    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  wsum;
    logic signed [SUM_W-1:0]  t_ext;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_reg <= PROD_W'($signed(rot_row[47:32])) * PROD_W'(cam_x);
            p1_reg <= PROD_W'($signed(rot_row[31:16])) * PROD_W'(cam_y);
            p2_reg <= PROD_W'($signed(rot_row[15:0])) * $signed(PROD_W'(cam_z));
            sum_reg <= SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg)
                       + SUM_W'(8192);
            world_reg <= (wsum > SUM_W'(32'sh7FFF_FFFF)) ? 32'h7FFF_FFFF :
                         (wsum < -SUM_W'(33'sh0_8000_0000)) ? 32'h8000_0000 :
                         wsum[31:0];
        end
    end

    // round the Q14 product sum, then add translation scaled to Q16
    always_comb begin
        shifted = sum_reg >>> 14;
        t_ext   = SUM_W'($signed(trans)) <<< 8;
        wsum    = shifted + t_ext;
    end

    assign world = world_reg;

endmodule

// ----- design/depth_pixel_backprojector_core.sv -----
// Depth pixel back-projector: takes one depth pixel per transfer and, for
// pixels on the stride grid with depth between 0.01 m and 100 m, returns one
// colored world point (pinhole back-projection, then rotation and
// translation from the configuration registers); other pixels return nothing.
// A pixel enters every cycle while the pipeline advances; a point passes
// through four front-end stages, 42 stages of the bit-per-stage restoring
// dividers that form (16*col-cx)*z/fx and (16*row-cy)*z/fy, one sign stage,
// three transform stages and the output register. A stall at the output holds
// the whole pipeline only while its last stage carries a point.
module depth_pixel_backprojector_core #(
    parameter int PIXEL_STRIDE = 3,
    parameter int COORD_BITS   = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pixel_row, pixel_col, depth_value, blue_in, green_in, red_in, mask_value
    input  logic [79:0]                      s_tdata,
    // mask_present
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // world_x, world_y, world_z, blue_out, green_out, red_out
    output logic [119:0]                     m_tdata,
    input  logic                             cfg_we,
    input  logic [dpb_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  logic [dpb_pkg::REG_DATA_W-1:0]   cfg_wdata
);
    import dpb_pkg::*;

    localparam int CB_EFF = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam logic [12:0] COORD_MASK13 = (13'd1 << CB_EFF) - 13'd1;
    localparam logic [11:0] COORD_MASK = COORD_MASK13[11:0];
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_MUL = ((1 << RECIP_SHIFT) + PIXEL_STRIDE - 1) / PIXEL_STRIDE;
    localparam logic [24:0] RECIP = 25'(RECIP_MUL);
    localparam logic [4:0] STRIDE = 5'(PIXEL_STRIDE);
    localparam int AX_LAT = 3;
    localparam int SIDE_X_W = 2 + 24 + COLOR_W;

    cfg_t cfg;

    dpb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic adv;
    logic tail_emit;
    logic m_tvalid_reg;

    // advance unless a point waits at the end and the output cannot take it
    assign adv      = !m_tvalid_reg || m_tready || !tail_emit;
    assign s_tready = adv;

    // stage 1: capture
    logic               v1_reg;
    logic [11:0]        row1_reg, col1_reg;
    logic [23:0]        z1_reg;
    logic [COLOR_W-1:0] color1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            row1_reg   <= s_tdata[11:0] & COORD_MASK;
            col1_reg   <= s_tdata[23:12] & COORD_MASK;
            z1_reg     <= s_tdata[47:24];
            color1_reg[15:0]  <= s_tdata[63:48];
            color1_reg[23:16] <= (s_tuser[0] && s_tdata[79:72] > MASK_LIMIT) ?
                                 RED_FULL : s_tdata[71:64];
        end
    end

    // stage 2: stride quotients, centered coordinates, depth band
    logic               v2_reg;
    logic [11:0]        row2_reg, col2_reg, qrow2_reg, qcol2_reg;
    logic signed [16:0] numx2_reg, numy2_reg;
    logic               dok2_reg;
    logic [23:0]        z2_reg;
    logic [COLOR_W-1:0] color2_reg;
    logic [36:0]        row_prod, col_prod;

    assign row_prod = 37'(row1_reg) * 37'(RECIP);
    assign col_prod = 37'(col1_reg) * 37'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            row2_reg   <= row1_reg;
            col2_reg   <= col1_reg;
            qrow2_reg  <= row_prod[RECIP_SHIFT+11:RECIP_SHIFT];
            qcol2_reg  <= col_prod[RECIP_SHIFT+11:RECIP_SHIFT];
            numx2_reg  <= $signed({1'b0, col1_reg, 4'b0}) - $signed({1'b0, cfg.center_x});
            numy2_reg  <= $signed({1'b0, row1_reg, 4'b0}) - $signed({1'b0, cfg.center_y});
            dok2_reg   <= (z1_reg >= DEPTH_MIN) && (z1_reg <= DEPTH_MAX);
            z2_reg     <= z1_reg;
            color2_reg <= color1_reg;
        end
    end

    // stage 3: keep decision, magnitude products
    logic               v3_reg, keep3_reg, sx3_reg, sy3_reg;
    logic [39:0]        magx3_reg, magy3_reg;
    logic [23:0]        z3_reg;
    logic [COLOR_W-1:0] color3_reg;
    logic [16:0]        absx, absy;

    assign absx = numx2_reg[16] ? 17'(-numx2_reg) : 17'(numx2_reg);
    assign absy = numy2_reg[16] ? 17'(-numy2_reg) : 17'(numy2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            keep3_reg  <= dok2_reg
                          && ({5'b0, row2_reg} == 17'(qrow2_reg) * 17'(STRIDE))
                          && ({5'b0, col2_reg} == 17'(qcol2_reg) * 17'(STRIDE));
            sx3_reg    <= numx2_reg[16];
            sy3_reg    <= numy2_reg[16];
            magx3_reg  <= 40'(absx[15:0]) * 40'(z2_reg);
            magy3_reg  <= 40'(absy[15:0]) * 40'(z2_reg);
            z3_reg     <= z2_reg;
            color3_reg <= color2_reg;
        end
    end

    // stage 4: rounding offset, 2*mag + f over 2*f
    logic                v4_reg;
    logic [NUM_W-1:0]    nx4_reg, ny4_reg;
    logic [SIDE_X_W-1:0] sidex4_reg;
    logic                sy4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx4_reg    <= NUM_W'({magx3_reg, 1'b0}) + NUM_W'(cfg.focal_x);
            ny4_reg    <= NUM_W'({magy3_reg, 1'b0}) + NUM_W'(cfg.focal_y);
            sidex4_reg <= {keep3_reg, sx3_reg, z3_reg, color3_reg};
            sy4_reg    <= sy3_reg;
        end
    end

    logic                vx_div, vy_div;
    logic [NUM_W-1:0]    qx_div, qy_div;
    logic [SIDE_X_W-1:0] sidex_div;
    logic [0:0]          sidey_div;

    dpb_div_pipe #(.N_W(NUM_W), .D_W(DEN_W), .SIDE_W(SIDE_X_W)) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_num    (nx4_reg),
        .in_side   (sidex4_reg),
        .den       ({cfg.focal_x, 1'b0}),
        .out_valid (vx_div),
        .out_quo   (qx_div),
        .out_side  (sidex_div)
    );

    dpb_div_pipe #(.N_W(NUM_W), .D_W(DEN_W), .SIDE_W(1)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_num    (ny4_reg),
        .in_side   (sy4_reg),
        .den       ({cfg.focal_y, 1'b0}),
        .out_valid (vy_div),
        .out_quo   (qy_div),
        .out_side  (sidey_div)
    );

    // stage 5: apply signs, drop pixels off the grid or out of band
    logic                    v5_reg;
    logic signed [CAM_W-1:0] x5_reg, y5_reg;
    logic [23:0]             z5_reg;
    logic [COLOR_W-1:0]      color5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= vx_div && vy_div && sidex_div[SIDE_X_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x5_reg     <= sidex_div[SIDE_X_W-2] ? -$signed(qx_div) : $signed(qx_div);
            y5_reg     <= sidey_div[0] ? -$signed(qy_div) : $signed(qy_div);
            z5_reg     <= sidex_div[COLOR_W+23:COLOR_W];
            color5_reg <= sidex_div[COLOR_W-1:0];
        end
    end

    logic [31:0] wx, wy, wz;

    dpb_axis u_axis_x (
        .aclk (aclk), .adv (adv), .rot_row (cfg.rot_a), .trans (cfg.translation[62:42]),
        .cam_x (x5_reg), .cam_y (y5_reg), .cam_z (z5_reg), .world (wx)
    );

    dpb_axis u_axis_y (
        .aclk (aclk), .adv (adv), .rot_row (cfg.rot_b), .trans (cfg.translation[41:21]),
        .cam_x (x5_reg), .cam_y (y5_reg), .cam_z (z5_reg), .world (wy)
    );

    dpb_axis u_axis_z (
        .aclk (aclk), .adv (adv), .rot_row (cfg.rot_c), .trans (cfg.translation[20:0]),
        .cam_x (x5_reg), .cam_y (y5_reg), .cam_z (z5_reg), .world (wz)
    );

    // color and valid follow the transform stages
    logic               tail_vld_reg   [AX_LAT];
    logic [COLOR_W-1:0] tail_color_reg [AX_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AX_LAT; i++) begin
                tail_vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            tail_vld_reg[0] <= v5_reg;
            for (int i = 1; i < AX_LAT; i++) begin
                tail_vld_reg[i] <= tail_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tail_color_reg[0] <= color5_reg;
            for (int i = 1; i < AX_LAT; i++) begin
                tail_color_reg[i] <= tail_color_reg[i-1];
            end
        end
    end

    assign tail_emit = tail_vld_reg[AX_LAT-1];

    // output register
    logic [119:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv && tail_emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_emit) begin
            m_tdata_reg <= {tail_color_reg[AX_LAT-1], wz, wy, wx};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready && tail_emit) |-> !adv)
        else $error("pipeline advanced over a waiting point");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && tail_emit) |=> m_tvalid)
        else $error("emitted point did not reach the output");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!m_tvalid && !tail_emit && !v5_reg))
        else $error("pipeline not empty after reset");

endmodule

// ----- verif/depth_pixel_backprojector_core_tb.sv -----
module depth_pixel_backprojector_core_tb;
    import dpb_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 300;

    typedef struct {
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] wz;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } point_t;

    class point_scoreboard;
        bit [62:0] regs [8];
        point_t    points_due [$];
        int        mismatches;
        int        points_seen;

        function new();
            regs[REG_FOCAL_X]     = FOCAL_RESET;
            regs[REG_FOCAL_Y]     = FOCAL_RESET;
            regs[REG_CENTER_X]    = CENTER_X_RESET;
            regs[REG_CENTER_Y]    = CENTER_Y_RESET;
            regs[REG_ROT_A]       = ROT_A_RESET;
            regs[REG_ROT_B]       = ROT_B_RESET;
            regs[REG_ROT_C]       = ROT_C_RESET;
            regs[REG_TRANSLATION] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, bit [62:0] value);
            bit [62:0] mask;
            case (idx)
                REG_FOCAL_X, REG_FOCAL_Y: mask = 63'hFFFFF;
                REG_CENTER_X, REG_CENTER_Y: mask = 63'hFFFF;
                REG_ROT_A, REG_ROT_B, REG_ROT_C: mask = 63'hFFFF_FFFF_FFFF;
                default: mask = '1;
            endcase
            regs[idx] = value & mask;
        endfunction

        // round(num * z / f), ties away from zero
        function longint project(longint num, longint z, longint f);
            longint mag;
            longint q;
            if (f == 0) f = 1;
            mag = (num < 0 ? -num : num) * z;
            q = (2 * mag + f) / (2 * f);
            return (num < 0) ? -q : q;
        endfunction

        function logic [31:0] world_axis(bit [47:0] rot, longint cx, longint cy, longint cz,
                                         bit [20:0] t);
            longint s;
            s = longint'($signed(rot[47:32])) * cx + longint'($signed(rot[31:16])) * cy
                + longint'($signed(rot[15:0])) * cz;
            s = (s + 8192) >>> 14;
            s = s + 256 * longint'($signed(t));
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s[31:0];
        endfunction

        function void note_pixel(logic [79:0] pix, logic present);
            logic [11:0] row;
            logic [11:0] col;
            logic [23:0] depth;
            longint camx;
            longint camy;
            point_t p;
            row = pix[11:0];
            col = pix[23:12];
            depth = pix[47:24];
            if (row % 3 != 0 || col % 3 != 0) return;
            if (depth < DEPTH_MIN || depth > DEPTH_MAX) return;
            camx = project(longint'(col) * 16 - longint'(regs[REG_CENTER_X]), longint'(depth),
                           longint'(regs[REG_FOCAL_X]));
            camy = project(longint'(row) * 16 - longint'(regs[REG_CENTER_Y]), longint'(depth),
                           longint'(regs[REG_FOCAL_Y]));
            p.wx = world_axis(regs[REG_ROT_A][47:0], camx, camy, longint'(depth),
                              regs[REG_TRANSLATION][62:42]);
            p.wy = world_axis(regs[REG_ROT_B][47:0], camx, camy, longint'(depth),
                              regs[REG_TRANSLATION][41:21]);
            p.wz = world_axis(regs[REG_ROT_C][47:0], camx, camy, longint'(depth),
                              regs[REG_TRANSLATION][20:0]);
            p.blue = pix[55:48];
            p.green = pix[63:56];
            p.red = (present && pix[79:72] > MASK_LIMIT) ? RED_FULL : pix[71:64];
            points_due.insert(points_due.size(), p);
        endfunction

        function void check_point(logic [119:0] d);
            point_t e;
            points_seen++;
            if (points_due.size() == 0) begin
                $display("%0t: unexpected point %h", $time, d);
                mismatches++;
                return;
            end
            e = points_due.pop_front();
            if (d[31:0] !== e.wx) begin
                $display("%0t: world_x expected %h actual %h", $time, e.wx, d[31:0]);
                mismatches++;
            end
            if (d[63:32] !== e.wy) begin
                $display("%0t: world_y expected %h actual %h", $time, e.wy, d[63:32]);
                mismatches++;
            end
            if (d[95:64] !== e.wz) begin
                $display("%0t: world_z expected %h actual %h", $time, e.wz, d[95:64]);
                mismatches++;
            end
            if (d[103:96] !== e.blue) begin
                $display("%0t: blue expected %h actual %h", $time, e.blue, d[103:96]);
                mismatches++;
            end
            if (d[111:104] !== e.green) begin
                $display("%0t: green expected %h actual %h", $time, e.green, d[111:104]);
                mismatches++;
            end
            if (d[119:112] !== e.red) begin
                $display("%0t: red expected %h actual %h", $time, e.red, d[119:112]);
                mismatches++;
            end
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [79:0]   s_tdata = '0;
    logic [0:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [119:0]  m_tdata;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_addr = '0;
    logic [62:0]   cfg_wdata = '0;

    point_scoreboard sb = new();
    bit  no_idle = 1'b0;
    int  ready_hold = 0;
    int  cycles = 0;
    int  pixels_sent = 0;

    depth_pixel_backprojector_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready = 1'b0;
            ready_hold--;
        end else begin
            m_tready = aresetn;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_point(m_tdata);
            ready_hold = no_idle ? 0 : $urandom_range(0, 3);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [62:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic load_camera(logic [19:0] fx, logic [19:0] fy, logic [15:0] cx,
                               logic [15:0] cy, logic [47:0] ra, logic [47:0] rb,
                               logic [47:0] rc, logic [62:0] t);
        write_reg(REG_FOCAL_X, 63'(fx));
        write_reg(REG_FOCAL_Y, 63'(fy));
        write_reg(REG_CENTER_X, 63'(cx));
        write_reg(REG_CENTER_Y, 63'(cy));
        write_reg(REG_ROT_A, 63'(ra));
        write_reg(REG_ROT_B, 63'(rb));
        write_reg(REG_ROT_C, 63'(rc));
        write_reg(REG_TRANSLATION, t);
    endtask

    task automatic send_pixel(logic [11:0] row, logic [11:0] col, logic [23:0] depth,
                              logic [7:0] b, logic [7:0] g, logic [7:0] r,
                              logic [7:0] mask, logic present);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {mask, r, g, b, depth, col, row};
        s_tuser = present;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(s_tdata, s_tuser[0]);
        pixels_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.points_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_pixel();
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] depth;
        if ($urandom_range(0, 99) < 85) begin
            row = 12'(3 * $urandom_range(0, 1365));
            col = 12'(3 * $urandom_range(0, 1365));
            case ($urandom_range(0, 3))
                0: depth = 24'($urandom_range(DEPTH_MIN, DEPTH_MIN + 20000));
                1: depth = 24'($urandom_range(DEPTH_MAX - 20000, DEPTH_MAX));
                default: depth = 24'($urandom_range(DEPTH_MIN, DEPTH_MAX));
            endcase
        end else begin
            row = 12'($urandom);
            col = 12'($urandom);
            depth = 24'($urandom);
        end
        send_pixel(row, col, depth, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 1'($urandom));
    endtask

    task automatic random_phase(int phase);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 100 == 0) no_idle = (i == 100);
            // in phase 2, hold the sender halfway until the pipe is empty
            if (phase == 2 && i == 150) drain();
            random_pixel();
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset camera, band edges, stride misses and mask cases
        send_pixel(12'd0, 12'd0, DEPTH_MIN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(12'd4095, 12'd4095, DEPTH_MAX, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(12'd3, 12'd6, DEPTH_MIN - 1, 8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
        send_pixel(12'd3, 12'd6, DEPTH_MAX + 1, 8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
        send_pixel(12'd9, 12'd9, 24'd0, 8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
        send_pixel(12'd9, 12'd9, 24'hFFFFFF, 8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
        send_pixel(12'd1, 12'd0, 24'h10000, 8'd5, 8'd6, 8'd7, 8'd0, 1'b0);
        send_pixel(12'd0, 12'd2, 24'h10000, 8'd5, 8'd6, 8'd7, 8'd0, 1'b0);
        send_pixel(12'd4094, 12'd4093, 24'h10000, 8'd5, 8'd6, 8'd7, 8'd0, 1'b0);
        send_pixel(12'd240, 12'd320, 24'h10000, 8'd10, 8'd20, 8'd30, 8'd129, 1'b1);
        send_pixel(12'd240, 12'd320, 24'h10000, 8'd10, 8'd20, 8'd30, 8'd128, 1'b1);
        send_pixel(12'd240, 12'd320, 24'h10000, 8'd10, 8'd20, 8'd30, 8'd255, 1'b0);
        send_pixel(12'd240, 12'd321, 24'h10000, 8'd10, 8'd20, 8'd30, 8'd255, 1'b1);
        send_pixel(12'd1200, 12'd2400, 24'h123456, 8'hAA, 8'h55, 8'h0F, 8'd200, 1'b1);
        drain();

        random_phase(0);
        // smallest focal, full-scale rotation and translation: saturates
        load_camera(20'd1, 20'd1, 16'd0, 16'd0, 48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF,
                    48'h7FFF_8000_7FFF, {21'h0FFFFF, 21'h100000, 21'h1FFFFF});
        random_phase(1);
        // zero focal acts as one
        load_camera(20'd0, 20'd0, 16'hFFFF, 16'hFFFF, 48'h8000_8000_8000,
                    48'h0000_0000_0000, 48'h8000_7FFF_0001,
                    {21'h100000, 21'h0FFFFF, 21'h000001});
        random_phase(2);
        load_camera(20'hFFFFF, 20'hFFFFF, 16'd32768, 16'd100, 48'h0000_4000_0000,
                    48'hC000_0000_0000, 48'h0000_0000_4000, 63'h0);
        random_phase(3);
        for (int k = 4; k < 6; k++) begin
            load_camera(20'($urandom_range(1, 20000)), 20'($urandom_range(1, 20000)),
                        16'($urandom), 16'($urandom), 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        63'({$urandom, $urandom}));
            random_phase(k);
        end

        $display("Sent %0d depth pixels over six camera settings, %0d world points checked.",
                 pixels_sent, sb.points_seen);
        if (sb.mismatches == 0 && sb.points_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- depth_pixel_backprojector_core.f -----
design/dpb_pkg.sv
design/dpb_cfg_regs.sv
design/dpb_div_pipe.sv
design/dpb_axis.sv
design/depth_pixel_backprojector_core.sv
verif/depth_pixel_backprojector_core_tb.sv
